>>> sv/lee_pkg.sv
package lee_pkg;

  localparam int MaxRun = 8;
  localparam int RunCntW = $clog2(MaxRun + 1);
  localparam int RunIdxW = $clog2(MaxRun);

  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharDot    = 8'h2e;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharNl     = 8'h0a;
  localparam logic [7:0] CharLowF   = 8'h20;
  localparam logic [7:0] CharHighF  = 8'h7e;
  localparam logic [3:0] NibMask    = 4'hf;

  // one item's worth of escaped characters
  typedef struct packed {
    logic [MaxRun-1:0][7:0] chars;
    logic [RunCntW-1:0]     count;
  } burst_t;

  function automatic logic [7:0] from_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h46;  // F
      2'd1:    c = 8'h72;  // r
      2'd2:    c = 8'h6f;  // o
      default: c = 8'h6d;  // m
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else if (upper) begin
      c = 8'h41 + {4'd0, nib} - 8'd10;
    end else begin
      c = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> sv/lee_in_if.sv
interface lee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

>>> sv/lee_out_if.sv
interface lee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

>>> sv/lee_cfg_if.sv
interface lee_cfg_if;
  logic valid;
  logic ready;
  logic hex_uppercase;

  modport source (output valid, output hex_uppercase, input ready);
  modport sink (input valid, input hex_uppercase, output ready);
endinterface

>>> sv/lee_encoder.sv
module lee_encoder import lee_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  lee_in_if.sink  in_if,
  lee_cfg_if.sink cfg_if,
  output burst_t burst,
  output logic   burst_valid,
  input  logic   burst_ready
);

  logic [7:0] byte_r;
  logic       eol_r;
  logic       valid_r;
  logic       at_start_r, at_start_nxt;
  logic [1:0] held_r, held_nxt;
  logic       upper_r;

  logic                lead_bs;
  logic [2:0]          n_held;
  logic                enc_on;
  logic                tail_on;
  logic                hold;
  logic [1:0]          enc_n;
  logic [2:0][7:0]     enc_c;
  logic [RunCntW-1:0]  pos;
  logic                printable;
  logic                adv;

  // escaped form of the current byte
  always_comb begin
    printable = (byte_r >= CharLowF && byte_r <= CharHighF) ||
                byte_r == CharTab || byte_r == CharNl;
    enc_c = '0;
    if (byte_r == CharBslash) begin
      enc_n = 2'd2;
      enc_c[0] = CharBslash;
      enc_c[1] = CharBslash;
    end else if (printable) begin
      enc_n = 2'd1;
      enc_c[0] = byte_r;
    end else begin
      enc_n = 2'd3;
      enc_c[0] = CharBslash;
      enc_c[1] = hex_digit(byte_r[7:4] & NibMask, upper_r);
      enc_c[2] = hex_digit(byte_r[3:0] & NibMask, upper_r);
    end
  end

  // line-start and prefix decisions
  always_comb begin
    lead_bs = 1'b0;
    n_held  = 3'd0;
    enc_on  = 1'b1;
    hold    = 1'b0;
    held_nxt = 2'd0;
    if (held_r != 2'd0) begin
      n_held = {1'b0, held_r};
      if (byte_r == from_char(held_r)) begin
        if (held_r == 2'd3) begin
          lead_bs = 1'b1;
          n_held  = 3'd4;
          enc_on  = 1'b0;
        end else if (!eol_r) begin
          hold     = 1'b1;
          held_nxt = held_r + 2'd1;
        end
      end
    end else if (at_start_r) begin
      if (byte_r == CharDot || byte_r == CharBang) begin
        lead_bs = 1'b1;
      end else if (byte_r == from_char(2'd0) && !eol_r) begin
        hold     = 1'b1;
        held_nxt = 2'd1;
      end
    end
    tail_on = !hold && eol_r && byte_r != CharNl;
    at_start_nxt = hold ? 1'b0 : eol_r;
  end

  // pack the run of characters in output order
  always_comb begin
    burst = '0;
    pos = '0;
    if (lead_bs) begin
      burst.chars[pos[RunIdxW-1:0]] = CharBslash;
      pos = pos + 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < n_held) begin
        burst.chars[pos[RunIdxW-1:0]] = from_char(2'(i));
        pos = pos + 1'b1;
      end
    end
    if (enc_on) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < enc_n) begin
          burst.chars[pos[RunIdxW-1:0]] = enc_c[i];
          pos = pos + 1'b1;
        end
      end
    end
    if (tail_on) begin
      burst.chars[pos[RunIdxW-1:0]] = CharBslash;
      pos = pos + 1'b1;
      burst.chars[pos[RunIdxW-1:0]] = CharNl;
      pos = pos + 1'b1;
    end
    if (hold) begin
      pos = '0;
    end
    burst.count = pos;
  end

  assign burst_valid  = valid_r && !hold;
  assign adv          = valid_r && (burst_ready || hold);
  assign in_if.ready  = !valid_r || adv;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      at_start_r <= 1'b1;
      held_r     <= 2'd0;
      upper_r    <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        upper_r <= cfg_if.hex_uppercase;
      end
      if (adv) begin
        at_start_r <= at_start_nxt;
        held_r     <= held_nxt;
      end
      if (in_if.ready) begin
        valid_r <= in_if.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.in_byte;
      eol_r  <= in_if.end_of_line;
    end
  end

endmodule

>>> sv/lee_serializer.sv
module lee_serializer import lee_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  burst_t burst,
  input  logic   burst_valid,
  output logic   burst_ready,
  lee_out_if.source out_if
);

  burst_t             run_r;
  logic [RunIdxW-1:0] idx_r;
  logic               busy_r;
  logic               last;

  assign last = ({1'b0, idx_r} + 1'b1) == run_r.count;

  assign out_if.valid       = busy_r;
  assign out_if.out_char    = run_r.chars[idx_r];
  assign out_if.last_of_run = last;
  assign burst_ready        = !busy_r || (out_if.ready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (burst_ready) begin
      busy_r <= burst_valid;
      idx_r  <= '0;
    end else if (out_if.ready) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_ready && burst_valid) begin
      run_r <= burst;
    end
  end

endmodule

>>> sv/line_escape_encoder_unit.sv
// Escapes a text byte stream line by line: leading '.', '!' or "From" gets a
// backslash, backslashes double, non-printable bytes become \xx hex, and a
// line not ending in newline gets backslash-newline appended. A byte is taken
// into an input register, escaped into a run of up to eight characters that
// is registered in the serializer, and the run is shifted out one character per
// cycle while the output is ready; a new byte is accepted every cycle as long as
// the output keeps up and each run is one character. A byte producing several
// characters holds the output port until its run is shifted out; bytes held as
// a possible "From" prefix produce nothing.
module line_escape_encoder_unit import lee_pkg::*; (
  input logic clk,
  input logic rst_n,
  lee_in_if.sink    in_if,
  lee_out_if.source out_if,
  lee_cfg_if.sink   cfg_if
);

  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  lee_encoder u_encoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .cfg_if      (cfg_if),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready)
  );

  lee_serializer u_serializer (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .out_if      (out_if)
  );

endmodule
